// ===== rtl/sbc_pkg.sv =====
// Shared widths, constants and types of the swept box collision pipeline.
// Used by sbc_div, swept_box_collision and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package sbc_pkg;

  // field widths
  localparam int COORD_W = 24;
  localparam int SIZE_W  = 23;
  localparam int FT_W    = 16;
  localparam int KIND_W  = 2;
  localparam int TFRAC_W = 16;

  // derived datapath widths
  localparam int NUMER_W   = COORD_W + 2;                   // edge offset, signed
  localparam int DISP_W    = COORD_W + FT_W;                // displacement, signed
  localparam int NUM_W     = NUMER_W - 1 + FT_W + TFRAC_W;  // dividend magnitude
  localparam int DEN_W     = DISP_W;                        // divisor magnitude
  localparam int DIV_STEPS = NUM_W;                         // one quotient bit a stage
  localparam int TIME_W    = 62;                            // axis time, holds infinity
  localparam int TC_W      = TFRAC_W + 2;                   // clamped hit time
  localparam int CEN_W     = COORD_W + 2;                   // doubled centre
  localparam int PROD_W    = TC_W + DISP_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int PIX_W     = COORD_W - 8;
  localparam int CEN_SH    = TFRAC_W + 15;
  localparam int RND_SH    = TFRAC_W + 24;
  localparam int NRM_W     = 2;

  // stream payload widths
  localparam int S_DATA_W = 240;
  localparam int S_USER_W = KIND_W;
  localparam int M_DATA_W = 56;
  localparam int M_USER_W = KIND_W + 1;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [FT_W-1:0] FT_RESET = 16'd1092;

  // result constants
  localparam logic [KIND_W-1:0] KIND_MISS = 2'd1;
  localparam logic signed [TIME_W-1:0] T_INF = {2'b01, {(TIME_W - 2){1'b0}}};
  localparam logic signed [TIME_W-1:0] T_ONE = TIME_W'(64'd1 << TFRAC_W);
  localparam logic signed [TIME_W-1:0] T_NEG2 =
    {{(TIME_W - TFRAC_W - 1){1'b1}}, {(TFRAC_W + 1){1'b0}}};
  localparam logic signed [TC_W-1:0] TC_MIN = {2'b10, {TFRAC_W{1'b0}}};
  localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W - 1){1'b1}}};
  localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W - 1){1'b0}}};
  localparam logic signed [NRM_W-1:0] NRM_POS = 2'sd1;
  localparam logic signed [NRM_W-1:0] NRM_NEG = -2'sd1;
  localparam logic signed [NRM_W-1:0] NRM_NONE = 2'sd0;

  // per-quotient special case flags
  typedef struct packed {
    logic bad;     // zero over zero
    logic inf;     // zero divisor
    logic infneg;  // infinity is negative
    logic qneg;    // quotient is negative
  } qflag_t;

  // data that rides beside the dividers
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [CEN_W-1:0]  cx;
    logic signed [CEN_W-1:0]  cy;
    logic signed [DISP_W-1:0] dx;
    logic signed [DISP_W-1:0] dy;
    logic                     zv;
    qflag_t [3:0]             qf;
  } side_t;

  // decided result before the contact point
  typedef struct packed {
    logic                    miss;
    logic signed [NRM_W-1:0] nrm_x;
    logic signed [NRM_W-1:0] nrm_y;
    logic signed [TC_W-1:0]  tc;
  } res_t;

endpackage

// ===== rtl/sbc_div.sv =====
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// Depends on sbc_pkg for the dividend, divisor and stage count.
`timescale 1ns / 1ps

module sbc_div
  import sbc_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [DIV_STEPS];
  logic [NUM_W-1:0] num_q [DIV_STEPS];
  logic [NUM_W-1:0] quo_q [DIV_STEPS];
  logic [DEN_W-1:0] den_q [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_sh;
    logic             fits;

    // stage inputs
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    // shift in the next dividend bit and try the subtract
    assign rem_sh = {rem_in[DEN_W-2:0], num_in[NUM_W-1]};
    assign fits   = (rem_sh >= den_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= fits ? (rem_sh - den_in) : rem_sh;
        num_q[s] <= {num_in[NUM_W-2:0], 1'b0};
        quo_q[s] <= {quo_in[NUM_W-2:0], fits};
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

// ===== rtl/swept_box_collision.sv =====
// Swept box collision tester: slab test of a moving box against a grown target.
// Throughput: one box pair per cycle while the output buffer is not full; the four 57-stage dividers set the depth.
// A two-entry output buffer keeps input open while a result waits.
// Reset (asynchronous, active low) empties the pipeline and sets frame_time to 1092.
// Depends on sbc_pkg and sbc_div.
`timescale 1ns / 1ps

module swept_box_collision
  import sbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // mover_x, mover_y, mover_width, mover_height, velocity_x, velocity_y,
  // target_x, target_y, target_width, target_height, zero pad
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // target_kind
  input  logic [S_USER_W-1:0] s_axis_tuser,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // contact_x, contact_y, normal_x, normal_y, hit_time, zero pad
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // hit, hit_kind
  output logic [M_USER_W-1:0] m_axis_tuser,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic            en;
  logic [FT_W-1:0] frame_time_q;

  // configuration register
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : PDATA_W'(frame_time_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_time_q <= FT_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      frame_time_q <= pwdata[FT_W-1:0];
    end
  end

  assign s_axis_tready = en;

  // ---------------- stage A: displacement and edge offsets
  logic signed [COORD_W-1:0] mov_x, mov_y, vel_x, vel_y, tgt_x, tgt_y;
  logic [SIZE_W-1:0]         mov_w, mov_h, tgt_w, tgt_h;
  logic signed [DISP_W:0]    disp_x, disp_y;
  logic signed [NUMER_W-1:0] a_num_d [4];
  side_t                     a_side_d;

  assign mov_x = s_axis_tdata[23:0];
  assign mov_y = s_axis_tdata[47:24];
  assign mov_w = s_axis_tdata[70:48];
  assign mov_h = s_axis_tdata[93:71];
  assign vel_x = s_axis_tdata[117:94];
  assign vel_y = s_axis_tdata[141:118];
  assign tgt_x = s_axis_tdata[165:142];
  assign tgt_y = s_axis_tdata[189:166];
  assign tgt_w = s_axis_tdata[212:190];
  assign tgt_h = s_axis_tdata[235:213];

  assign disp_x = vel_x * $signed({1'b0, frame_time_q});
  assign disp_y = vel_y * $signed({1'b0, frame_time_q});

  always_comb begin
    a_num_d[0] = NUMER_W'(tgt_x) - NUMER_W'(mov_x) - $signed(NUMER_W'(mov_w));
    a_num_d[1] = NUMER_W'(tgt_y) - NUMER_W'(mov_y) - $signed(NUMER_W'(mov_h));
    a_num_d[2] = NUMER_W'(tgt_x) + $signed(NUMER_W'(tgt_w)) - NUMER_W'(mov_x);
    a_num_d[3] = NUMER_W'(tgt_y) + $signed(NUMER_W'(tgt_h)) - NUMER_W'(mov_y);
    a_side_d.kind = s_axis_tuser;
    a_side_d.cx   = (CEN_W'(mov_x) <<< 1) + $signed(CEN_W'(mov_w));
    a_side_d.cy   = (CEN_W'(mov_y) <<< 1) + $signed(CEN_W'(mov_h));
    a_side_d.dx   = disp_x[DISP_W-1:0];
    a_side_d.dy   = disp_y[DISP_W-1:0];
    a_side_d.zv   = (vel_x == '0) && (vel_y == '0);
    a_side_d.qf   = '0;
  end

  logic                      a_v_q;
  logic signed [NUMER_W-1:0] a_num_q [4];
  side_t                     a_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_num_q  <= a_num_d;
      a_side_q <= a_side_d;
    end
  end

  // ---------------- stage B: magnitudes and special cases
  logic [NUM_W-1:0] b_n_d [4];
  logic [DEN_W-1:0] b_d_d [4];
  side_t            b_side_d;

  always_comb begin
    logic signed [NUMER_W-1:0] num;
    logic signed [NUMER_W-1:0] nmag;
    logic signed [DISP_W-1:0]  den;
    logic signed [DISP_W-1:0]  dmag;
    logic                      vneg;
    logic                      nneg;
    logic                      dz;
    b_side_d = a_side_q;
    for (int k = 0; k < 4; k++) begin
      num  = a_num_q[k];
      den  = (k % 2 == 1) ? a_side_q.dy : a_side_q.dx;
      vneg = den[DISP_W-1];
      nneg = num[NUMER_W-1];
      nmag = nneg ? -num : num;
      dmag = vneg ? -den : den;
      dz   = (den == '0);
      b_n_d[k] = {nmag[NUMER_W-2:0], {(NUM_W - NUMER_W + 1){1'b0}}};
      b_d_d[k] = dmag;
      b_side_d.qf[k].bad    = dz && (num == '0);
      b_side_d.qf[k].inf    = dz;
      b_side_d.qf[k].infneg = ~((~nneg) ^ ((k % 2 == 1) ? a_side_q.dy[DISP_W-1]
                                                        : a_side_q.dx[DISP_W-1]));
      b_side_d.qf[k].qneg   = nneg ^ vneg;
    end
  end

  // with a zero divisor the sign follows the velocity, which the
  // displacement carries only when frame_time is nonzero
  logic [1:0] a_vneg_q;
  logic  vx_neg_a, vy_neg_a;
  logic  b_vxn_q, b_vyn_q;
  assign vx_neg_a = a_vneg_q[0];
  assign vy_neg_a = a_vneg_q[1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_vneg_q <= {vel_y[COORD_W-1], vel_x[COORD_W-1]};
      b_vxn_q  <= vx_neg_a;
      b_vyn_q  <= vy_neg_a;
    end
  end

  logic             b_v_q;
  logic [NUM_W-1:0] b_n_q [4];
  logic [DEN_W-1:0] b_d_q [4];
  side_t            b_side_q;
  side_t            b_side_fix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_n_q    <= b_n_d;
      b_d_q    <= b_d_d;
      b_side_q <= b_side_d;
    end
  end

  // infinity sign uses the velocity sign, not the displacement sign
  always_comb begin
    b_side_fix = b_side_q;
    for (int k = 0; k < 4; k++) begin
      b_side_fix.qf[k].infneg = b_side_q.qf[k].infneg ^
        (((k % 2 == 1) ? b_vyn_q : b_vxn_q) ^
         ((k % 2 == 1) ? b_side_q.dy[DISP_W-1] : b_side_q.dx[DISP_W-1]));
    end
  end

  // ---------------- divider stages
  logic [NUM_W-1:0] quo [4];

  for (genvar k = 0; k < 4; k++) begin : g_div
    sbc_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (b_n_q[k]),
      .den_i (b_d_q[k]),
      .quo_o (quo[k])
    );
  end

  logic  dv_q [DIV_STEPS];
  side_t ds_q [DIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_STEPS; s++) dv_q[s] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= b_v_q;
      for (int s = 1; s < DIV_STEPS; s++) dv_q[s] <= dv_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ds_q[0] <= b_side_fix;
      for (int s = 1; s < DIV_STEPS; s++) ds_q[s] <= ds_q[s-1];
    end
  end

  // ---------------- stage C: signed axis times
  logic signed [TIME_W-1:0] c_t_d [4];
  logic                     c_miss_d;
  side_t                    dl_side;

  assign dl_side = ds_q[DIV_STEPS-1];

  always_comb begin
    logic signed [TIME_W-1:0] qs;
    c_miss_d = dl_side.zv;
    for (int k = 0; k < 4; k++) begin
      qs = TIME_W'(quo[k]);
      if (dl_side.qf[k].inf) begin
        c_t_d[k] = dl_side.qf[k].infneg ? -T_INF : T_INF;
      end else begin
        c_t_d[k] = dl_side.qf[k].qneg ? -qs : qs;
      end
      c_miss_d = c_miss_d | dl_side.qf[k].bad;
    end
  end

  logic                     c_v_q, c_miss_q;
  logic signed [TIME_W-1:0] c_t_q [4];
  side_t                    c_side_q;

  // ---------------- stage E: order entry and exit per axis
  logic signed [TIME_W-1:0] e_nx_d, e_fx_d, e_ny_d, e_fy_d;

  always_comb begin
    if (c_t_q[0] > c_t_q[2]) begin
      e_nx_d = c_t_q[2];
      e_fx_d = c_t_q[0];
    end else begin
      e_nx_d = c_t_q[0];
      e_fx_d = c_t_q[2];
    end
    if (c_t_q[1] > c_t_q[3]) begin
      e_ny_d = c_t_q[3];
      e_fy_d = c_t_q[1];
    end else begin
      e_ny_d = c_t_q[1];
      e_fy_d = c_t_q[3];
    end
  end

  logic                     e_v_q, e_miss_q;
  logic signed [TIME_W-1:0] e_nx_q, e_fx_q, e_ny_q, e_fy_q;
  side_t                    e_side_q;

  // ---------------- stage F: slab overlap, entry, exit and face normal
  logic                     f_miss_d;
  logic signed [TIME_W-1:0] f_tn_d, f_tf_d;
  logic signed [NRM_W-1:0]  f_nx_d, f_ny_d;

  always_comb begin
    f_miss_d = e_miss_q || (e_nx_q > e_fy_q) || (e_ny_q > e_fx_q);
    f_tn_d   = (e_nx_q > e_ny_q) ? e_nx_q : e_ny_q;
    f_tf_d   = (e_fx_q < e_fy_q) ? e_fx_q : e_fy_q;
    f_nx_d   = NRM_NONE;
    f_ny_d   = NRM_NONE;
    if (e_nx_q > e_ny_q) begin
      f_nx_d = e_side_q.dx[DISP_W-1] ? NRM_POS : NRM_NEG;
    end else if (e_nx_q < e_ny_q) begin
      f_ny_d = e_side_q.dy[DISP_W-1] ? NRM_POS : NRM_NEG;
    end
  end

  logic                     f_v_q, f_miss_q;
  logic signed [TIME_W-1:0] f_tn_q, f_tf_q;
  logic signed [NRM_W-1:0]  f_nx_q, f_ny_q;
  side_t                    f_side_q;

  // ---------------- stage G: frame window and time clamp
  res_t g_res_d;

  always_comb begin
    g_res_d.miss  = f_miss_q || (f_tf_q < 0) || (f_tn_q > T_ONE);
    g_res_d.nrm_x = f_nx_q;
    g_res_d.nrm_y = f_ny_q;
    g_res_d.tc    = (f_tn_q < T_NEG2) ? TC_MIN : f_tn_q[TC_W-1:0];
  end

  logic  g_v_q;
  res_t  g_res_q;
  side_t g_side_q;

  // ---------------- stage H: time times displacement
  logic signed [PROD_W-1:0] h_px_d, h_py_d;

  assign h_px_d = g_res_q.tc * g_side_q.dx;
  assign h_py_d = g_res_q.tc * g_side_q.dy;

  logic                     h_v_q;
  logic signed [PROD_W-1:0] h_px_q, h_py_q;
  res_t                     h_res_q;
  side_t                    h_side_q;

  // ---------------- stage I: add the centre
  logic signed [SUM_W-1:0] i_sx_d, i_sy_d;
  logic signed [SUM_W-1:0] cxw, cyw;

  assign cxw    = SUM_W'(h_side_q.cx);
  assign cyw    = SUM_W'(h_side_q.cy);
  assign i_sx_d = (cxw <<< CEN_SH) + SUM_W'(h_px_q);
  assign i_sy_d = (cyw <<< CEN_SH) + SUM_W'(h_py_q);

  logic                    i_v_q;
  logic signed [SUM_W-1:0] i_sx_q, i_sy_q;
  res_t                    i_res_q;
  logic [KIND_W-1:0]       i_kind_q;

  // ---------------- stage J: magnitude plus rounding half
  logic signed [SUM_W-1:0] j_mx_d, j_my_d;
  localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(64'd1 << (RND_SH - 1));

  assign j_mx_d = (i_sx_q[SUM_W-1] ? -i_sx_q : i_sx_q) + RND_HALF;
  assign j_my_d = (i_sy_q[SUM_W-1] ? -i_sy_q : i_sy_q) + RND_HALF;

  logic                    j_v_q, j_negx_q, j_negy_q;
  logic [SUM_W-1:0]        j_mx_q, j_my_q;
  res_t                    j_res_q;
  logic [KIND_W-1:0]       j_kind_q;

  // ---------------- stage K: shift, restore sign, saturate, pack
  localparam int RV_W = SUM_W - RND_SH + 1;

  logic signed [RV_W-1:0]  rvx, rvy;
  logic signed [PIX_W-1:0] pix_x, pix_y;
  logic [M_DATA_W-1:0]     k_data_d;
  logic [M_USER_W-1:0]     k_user_d;

  always_comb begin
    rvx = $signed({1'b0, j_mx_q[SUM_W-1:RND_SH]});
    rvy = $signed({1'b0, j_my_q[SUM_W-1:RND_SH]});
    if (j_negx_q) rvx = -rvx;
    if (j_negy_q) rvy = -rvy;
    if (rvx > PIX_MAX) pix_x = PIX_MAX;
    else if (rvx < PIX_MIN) pix_x = PIX_MIN;
    else pix_x = rvx[PIX_W-1:0];
    if (rvy > PIX_MAX) pix_y = PIX_MAX;
    else if (rvy < PIX_MIN) pix_y = PIX_MIN;
    else pix_y = rvy[PIX_W-1:0];
    if (j_res_q.miss) begin
      k_data_d = '0;
      k_user_d = {KIND_MISS, 1'b0};
    end else begin
      k_data_d = {2'b00, j_res_q.tc, j_res_q.nrm_y, j_res_q.nrm_x, pix_y, pix_x};
      k_user_d = {j_kind_q, 1'b1};
    end
  end

  logic                k_v_q;
  logic [M_DATA_W-1:0] k_data_q;
  logic [M_USER_W-1:0] k_user_q;

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
      j_v_q <= 1'b0;
      k_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= dv_q[DIV_STEPS-1];
      e_v_q <= c_v_q;
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
      h_v_q <= g_v_q;
      i_v_q <= h_v_q;
      j_v_q <= i_v_q;
      k_v_q <= j_v_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_t_q    <= c_t_d;
      c_miss_q <= c_miss_d;
      c_side_q <= dl_side;
      e_nx_q   <= e_nx_d;
      e_fx_q   <= e_fx_d;
      e_ny_q   <= e_ny_d;
      e_fy_q   <= e_fy_d;
      e_miss_q <= c_miss_q;
      e_side_q <= c_side_q;
      f_miss_q <= f_miss_d;
      f_tn_q   <= f_tn_d;
      f_tf_q   <= f_tf_d;
      f_nx_q   <= f_nx_d;
      f_ny_q   <= f_ny_d;
      f_side_q <= e_side_q;
      g_res_q  <= g_res_d;
      g_side_q <= f_side_q;
      h_px_q   <= h_px_d;
      h_py_q   <= h_py_d;
      h_res_q  <= g_res_q;
      h_side_q <= g_side_q;
      i_sx_q   <= i_sx_d;
      i_sy_q   <= i_sy_d;
      i_res_q  <= h_res_q;
      i_kind_q <= h_side_q.kind;
      j_mx_q   <= j_mx_d;
      j_my_q   <= j_my_d;
      j_negx_q <= i_sx_q[SUM_W-1];
      j_negy_q <= i_sy_q[SUM_W-1];
      j_res_q  <= i_res_q;
      j_kind_q <= i_kind_q;
      k_data_q <= k_data_d;
      k_user_q <= k_user_d;
    end
  end

  // ---------------- two-entry output buffer
  logic [M_DATA_W-1:0] ob_data_q [2];
  logic [M_USER_W-1:0] ob_user_q [2];
  logic [1:0]          cnt_q;
  logic                rd_q, wr_q;
  logic                push, pop;

  assign en            = (cnt_q != 2'd2);
  assign push          = en && k_v_q;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = ob_data_q[rd_q];
  assign m_axis_tuser  = ob_user_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ob_data_q[wr_q] <= k_data_q;
      ob_user_q[wr_q] <= k_user_q;
    end
  end

`ifndef NO_ASSERTIONS
  // buffer never holds more than two results
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer count out of range");

  // a push never lands on a full buffer
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q != 2'd2)) else $error("push into full output buffer");

  // a miss is the all-zero result with the miss kind
  a_miss_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tdata == '0 && m_axis_tuser[2:1] == KIND_MISS))
    else $error("miss result not cleared");

  // at most one normal component is set
  a_one_normal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[33:32] == 2'b00 || m_axis_tdata[35:34] == 2'b00))
    else $error("both normal components set");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the swept box collision stream block.
// Needs sbc_pkg and swept_box_collision; directed table then random pairs, checked in order.
`timescale 1ns / 1ps

module testbench;
  import sbc_pkg::*;

  // one box pair as it enters the block
  typedef struct packed {
    logic signed [23:0] mx;
    logic signed [23:0] my;
    logic [22:0]        mw;
    logic [22:0]        mh;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic [22:0]        tw;
    logic [22:0]        th;
    logic [1:0]         kind;
  } box_pair_t;

  // one collision result
  typedef struct packed {
    logic               hit;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [1:0]  nx;
    logic signed [1:0]  ny;
    logic signed [17:0] t;
    logic [1:0]         kind;
  } contact_t;

  // directed row: a pair, plus a typed-in miss where it is obvious
  typedef struct {
    box_pair_t pair;
    bit        known_miss;
  } stim_row_t;

  localparam longint SLAB_INF = 64'sd1 <<< 60;
  localparam logic [ADDR_W-1:0] REG_FRAME_TIME = 3'd0;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [S_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [M_USER_W-1:0] m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  longint   frame_time_q = 1092;
  contact_t pending_contacts[$];
  int       errors = 0;
  int       hits_seen = 0;
  int       misses_seen = 0;
  int       config_writes = 0;
  bit       hold_request = 1'b0;
  bit       recv_burst = 1'b0;

  swept_box_collision DUT (.*);

  always #6 clk_i = ~clk_i;

  // run limit
  initial begin
    #10ms;
    $display("timeout with %0d results outstanding", pending_contacts.size());
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
  endtask

  // slab entry or exit time; 0 when the axis is zero over zero
  function automatic bit slab_time(longint num, longint d, bit vneg, output longint t);
    t = 0;
    if (d == 0) begin
      if (num == 0) return 1'b0;
      t = ((num > 0) != vneg) ? SLAB_INF : -SLAB_INF;
      return 1'b1;
    end
    t = (num * (64'sd1 <<< 32)) / d;
    return 1'b1;
  endfunction

  function automatic longint round_half_away(longint p, int s);
    longint half;
    half = 64'sd1 <<< (s - 1);
    if (p >= 0) return (p + half) >>> s;
    return -((-p + half) >>> s);
  endfunction

  function automatic longint clamp_pix(longint p);
    if (p > 32767) return 32767;
    if (p < -32768) return -32768;
    return p;
  endfunction

  function automatic contact_t predict_contact(box_pair_t b);
    longint mx, my, mw, mh, vx, vy, tx, ty, tw, th;
    longint dx, dy, nx, ny, fx, fy, tmp, tn, tf, tc, px, py;
    contact_t r;
    r = '0;
    r.kind = KIND_MISS;
    mx = b.mx; my = b.my; mw = b.mw; mh = b.mh;
    vx = b.vx; vy = b.vy; tx = b.tx; ty = b.ty; tw = b.tw; th = b.th;
    if (vx == 0 && vy == 0) return r;
    dx = vx * frame_time_q;
    dy = vy * frame_time_q;
    if (!slab_time(tx - mx - mw, dx, vx < 0, nx)) return r;
    if (!slab_time(ty - my - mh, dy, vy < 0, ny)) return r;
    if (!slab_time(tx + tw - mx, dx, vx < 0, fx)) return r;
    if (!slab_time(ty + th - my, dy, vy < 0, fy)) return r;
    if (nx > fx) begin tmp = nx; nx = fx; fx = tmp; end
    if (ny > fy) begin tmp = ny; ny = fy; fy = tmp; end
    if (nx > fy || ny > fx) return r;
    tn = nx > ny ? nx : ny;
    tf = fx < fy ? fx : fy;
    if (tf < 0 || tn > 65536) return r;
    tc = tn < -131072 ? -131072 : tn;
    // centre in half-LSB units, scaled to the product's fraction
    px = (2 * mx + mw) * (64'sd1 <<< 31) + tc * dx;
    py = (2 * my + mh) * (64'sd1 <<< 31) + tc * dy;
    px = clamp_pix(round_half_away(px, 40));
    py = clamp_pix(round_half_away(py, 40));
    r.hit = 1'b1;
    r.cx = px[15:0];
    r.cy = py[15:0];
    r.nx = NRM_NONE;
    r.ny = NRM_NONE;
    if (nx > ny) r.nx = dx < 0 ? NRM_POS : NRM_NEG;
    else if (nx < ny) r.ny = dy < 0 ? NRM_POS : NRM_NEG;
    r.t = tc[17:0];
    r.kind = b.kind;
    return r;
  endfunction

  function automatic box_pair_t mk(longint mx, longint my, longint mw, longint mh,
                                   longint vx, longint vy, longint tx, longint ty,
                                   longint tw, longint th, int kind);
    box_pair_t b;
    b.mx = mx[23:0]; b.my = my[23:0]; b.mw = mw[22:0]; b.mh = mh[22:0];
    b.vx = vx[23:0]; b.vy = vy[23:0]; b.tx = tx[23:0]; b.ty = ty[23:0];
    b.tw = tw[22:0]; b.th = th[22:0]; b.kind = kind[1:0];
    return b;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint pick_extreme();
    case ($urandom_range(0, 4))
      0: return 8388607;
      1: return -8388608;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // random pair: mostly aimed at the target so the slab test gets deep
  function automatic box_pair_t random_pair();
    box_pair_t b;
    logic [255:0] raw;
    longint mx, my, offx, offy, vx, vy, scale;
    int style;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      b = raw[$bits(box_pair_t)-1:0];
      return b;
    end
    if (style == 1) begin
      b = mk(pick_extreme(), pick_extreme(), pick_extreme() & 23'h7fffff,
             pick_extreme() & 23'h7fffff, pick_extreme(), pick_extreme(), pick_extreme(),
             pick_extreme(), pick_extreme() & 23'h7fffff, pick_extreme() & 23'h7fffff,
             $urandom_range(0, 3));
      return b;
    end
    mx = longint'($urandom_range(0, 2097152)) - 1048576;
    my = longint'($urandom_range(0, 2097152)) - 1048576;
    offx = longint'($urandom_range(0, 51200)) - 25600;
    offy = longint'($urandom_range(0, 51200)) - 25600;
    // velocity that moves roughly the offset within one frame
    scale = frame_time_q == 0 ? 1 : frame_time_q;
    vx = sat24((offx * 65536 / scale) * $urandom_range(50, 150) / 100);
    vy = sat24((offy * 65536 / scale) * $urandom_range(50, 150) / 100);
    b = mk(mx, my, $urandom_range(0, 16384), $urandom_range(0, 16384), vx, vy,
           mx + offx, my + offy, $urandom_range(0, 16384), $urandom_range(0, 16384),
           $urandom_range(0, 3));
    // axis with no motion, sometimes with touching edges
    if (style == 2) begin
      b.vx = '0;
      if ($urandom_range(0, 1)) b.tx = b.mx + b.mw;
    end else if (style == 3) begin
      b.vy = '0;
      if ($urandom_range(0, 1)) b.ty = b.my + b.mh;
    end
    return b;
  endfunction

  // one transaction on the input stream, then the sender's gap
  task automatic send_pair(box_pair_t b, bit known_miss, int gap);
    contact_t want;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, b.th, b.tw, b.ty, b.tx, b.vy, b.vx, b.mh, b.mw, b.my, b.mx};
    s_axis_tuser <= b.kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = predict_contact(b);
    if (known_miss) begin
      want = '0;
      want.kind = KIND_MISS;
    end
    pending_contacts.insert(pending_contacts.size(), want);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_frame_time(longint value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_FRAME_TIME; pwdata <= value[31:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    frame_time_q = value & 16'hffff;
    config_writes++;
    // read back
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] != frame_time_q[15:0]) report("frame_time readback", prdata[15:0],
                                                   frame_time_q);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_contacts.size() != 0) @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        stall = recv_burst ? 0 : $urandom_range(0, 18);
      end
      if (hold_request && !held) begin
        held = 1'b1;
        stall = 600;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    contact_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit = m_axis_tuser[0];
      got.kind = m_axis_tuser[2:1];
      got.cx = m_axis_tdata[15:0];
      got.cy = m_axis_tdata[31:16];
      got.nx = m_axis_tdata[33:32];
      got.ny = m_axis_tdata[35:34];
      got.t = m_axis_tdata[53:36];
      if (pending_contacts.size() == 0) begin
        report("unexpected result transaction", got.hit, 0);
      end else begin
        want = pending_contacts.pop_front();
        if (got.hit) hits_seen++; else misses_seen++;
        if (got.hit != want.hit) report("hit", got.hit, want.hit);
        if (got.cx != want.cx) report("contact_x", got.cx, want.cx);
        if (got.cy != want.cy) report("contact_y", got.cy, want.cy);
        if (got.nx != want.nx) report("normal_x", got.nx, want.nx);
        if (got.ny != want.ny) report("normal_y", got.ny, want.ny);
        if (got.t != want.t) report("hit_time", got.t, want.t);
        if (got.kind != want.kind) report("hit_kind", got.kind, want.kind);
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t rows[$];
    longint frame_settings[PHASES];
    bit send_burst;
    int gap;
    frame_settings = '{1092, 65535, 0, 1, 0, 1092};
    frame_settings[4] = $urandom_range(2, 65534);

    // zero velocity misses, at the field extremes too
    rows.insert(rows.size(), '{mk(0, 0, 2560, 2560, 0, 0, 0, 0, 2560, 2560, 3), 1});
    rows.insert(rows.size(), '{mk(8388607, -8388608, 8388607, 8388607, 0, 0,
                                  -8388608, 8388607, 8388607, 8388607, 0), 1});
    // zero over zero: no x motion and the edges touch
    rows.insert(rows.size(), '{mk(0, 0, 2560, 2560, 0, 6000, 2560, 25600, 2560, 2560, 2), 1});
    // plain hits along each axis, both signs
    rows.insert(rows.size(), '{mk(0, 0, 2560, 2560, 1536000, 0, 25600, 0, 2560, 2560, 2), 0});
    rows.insert(rows.size(), '{mk(0, 0, 2560, 2560, -1536000, 0, -25600, 0, 2560, 2560, 0),
                               0});
    rows.insert(rows.size(), '{mk(0, 0, 2560, 2560, 0, 1536000, 0, 25600, 2560, 2560, 3), 0});
    rows.insert(rows.size(), '{mk(0, 0, 2560, 2560, 0, -1536000, 0, -25600, 2560, 2560, 1),
                               0});
    // diagonal corner hit: equal entry times give no normal
    rows.insert(rows.size(), '{mk(0, 0, 2560, 2560, 1536000, 1536000, 25600, 25600,
                                  2560, 2560, 2), 0});
    // no x motion while inside the x slab: infinite slab times
    rows.insert(rows.size(), '{mk(0, 0, 2560, 2560, 0, 1536000, 512, 25600, 2560, 2560, 3),
                               0});
    // already overlapping with slow motion: hit time clamps at -2
    rows.insert(rows.size(), '{mk(0, 0, 2560, 2560, 1, 0, 256, 256, 2560, 2560, 2), 0});
    // target too far for this frame
    rows.insert(rows.size(), '{mk(0, 0, 2560, 2560, 256, 0, 2560000, 0, 2560, 2560, 3), 0});
    // moving away
    rows.insert(rows.size(), '{mk(0, 0, 2560, 2560, -1536000, 0, 25600, 0, 2560, 2560, 2),
                               0});
    // extremes that saturate the contact point
    rows.insert(rows.size(), '{mk(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                                  8388607, 8388607, 8388607, 8388607, 3), 0});
    rows.insert(rows.size(), '{mk(-8388608, -8388608, 0, 0, -8388608, -8388608,
                                  -8388608, -8388608, 0, 0, 0), 0});
    rows.insert(rows.size(), '{mk(-8388608, 0, 8388607, 0, 8388607, -1, 8388607, 0,
                                  8388607, 0, 1), 0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_pair(rows[i].pair, rows[i].known_miss, $urandom_range(0, 3));

    for (int ph = 0; ph < PHASES; ph++) begin
      s_axis_tvalid <= 1'b0;
      drain();
      write_frame_time(frame_settings[ph]);
      send_burst = 1'b0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // alternate bursty stretches with random gaps
        if (n % 60 == 0) begin
          send_burst = $urandom_range(0, 2) == 0;
          recv_burst = $urandom_range(0, 2) == 0;
        end
        // long receiver hold while the sender keeps offering fills the pipeline
        if (ph == 1 && n >= 20 && n < 120) begin
          hold_request = 1'b1;
          send_burst = 1'b1;
        end
        gap = send_burst ? 0 : $urandom_range(0, 18);
        send_pair(random_pair(), 1'b0, gap);
      end
    end
    s_axis_tvalid <= 1'b0;
    drain();
    repeat (80) @(posedge clk_i);

    $display("covered %0d frame_time writes, %0d hits and %0d misses checked",
             config_writes, hits_seen, misses_seen);
    if (errors == 0 && pending_contacts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
